// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock while out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent on the next clock
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lit_pkg.sv =====
// ----------------------------------------------------------------------------
// lit_pkg
// types and constants shared by the lane interval table
// ----------------------------------------------------------------------------
`default_nettype none

package lit_pkg;

    localparam int LANE_COUNT     = 8;
    localparam int MAX_BOUNDARIES = 16;
    localparam int POS_WIDTH      = 32;
    localparam int LANE_W         = 3;
    localparam int IDX_W          = $clog2(MAX_BOUNDARIES);
    localparam int CNT_W          = $clog2(MAX_BOUNDARIES + 1);
    localparam int ADDR_W         = $clog2(LANE_COUNT * MAX_BOUNDARIES);
    localparam int LSEL_W         = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef logic [POS_WIDTH-1:0] pos_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat and clear scan index
        logic scan_step; // compare memory word, advance index
        logic rd_issue;  // issue memory read at scan or shift address
        logic shift_rd;  // read address is shift source
        logic shift_wr;  // write shifted word
        logic wr_start;  // write new start
        logic wr_end;    // write new end and commit lane state
        logic q_rd_hi;   // read partner word for query
        logic finish;    // build result
    } lit_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic lane_ok;
        logic scan_done;   // search stopped (word >= key or end)
        logic scan_end;    // scan index reached the boundary count
        logic pre_reject;  // insert fails before scanning
        logic ins_reject;  // insert fails after scanning
        logic shift_done;  // nothing left to move
        logic q_miss;      // query fails after scanning
    } lit_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lit_ctrl.sv =====
// ----------------------------------------------------------------------------
// lit_ctrl
// sequencer for one insert or query at a time
// ----------------------------------------------------------------------------
`default_nettype none

module lit_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output lit_pkg::lit_cmd_t     cmd,
    input  wire lit_pkg::lit_sts_t sts
);
    import lit_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PRE, S_RD, S_CMP, S_SHRD, S_SHWR, S_WS, S_WE, S_QRD, S_QWAIT, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                if (!sts.lane_ok || sts.pre_reject) begin
                    state_next = S_FIN;
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_RD: state_next = S_CMP;
            S_CMP: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    if (sts.is_query) begin
                        if (sts.q_miss) begin
                            state_next = S_FIN;
                        end else begin
                            cmd.q_rd_hi = 1'b1;
                            state_next  = S_QRD;
                        end
                    end else if (sts.ins_reject) begin
                        state_next = S_FIN;
                    end else if (sts.scan_end) begin
                        state_next = S_WS;
                    end else begin
                        state_next = S_SHRD;
                    end
                end else begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_RD;
                end
            end
            S_SHRD: begin
                cmd.rd_issue = 1'b1;
                cmd.shift_rd = 1'b1;
                state_next   = S_SHWR;
            end
            S_SHWR: begin
                cmd.shift_wr = 1'b1;
                if (sts.shift_done) begin
                    state_next = S_WS;
                end else begin
                    state_next = S_SHRD;
                end
            end
            S_WS: begin
                cmd.wr_start = 1'b1;
                state_next   = S_WE;
            end
            S_WE: begin
                cmd.wr_end = 1'b1;
                state_next = S_FIN;
            end
            S_QRD:   state_next = S_QWAIT;
            S_QWAIT: state_next = S_FIN;
            S_FIN: begin
                // result register must be free or draining this cycle
                if (!out_valid_reg || out_ready) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, out_valid && !out_ready, out_valid, "result dropped")
    `ASSERT_NEXT(a_fin_out, aclk, aresetn, cmd.finish, out_valid, "no result after finish")
    `ASSERT_NEXT(a_load_pre, aclk, aresetn, cmd.load, state_reg == S_PRE, "load not followed by pre")

endmodule

`default_nettype wire

// ===== rtl/core/lit_dp.sv =====
// ----------------------------------------------------------------------------
// lit_dp
// boundary memory, per-lane state, scan and shift datapath
// ----------------------------------------------------------------------------
`default_nettype none

module lit_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_func,
    input  wire logic [lit_pkg::LANE_W-1:0] in_lane,
    input  wire lit_pkg::pos_t             in_a,
    input  wire lit_pkg::pos_t             in_b,
    input  wire lit_pkg::lit_cmd_t         cmd,
    output lit_pkg::lit_sts_t              sts,
    output logic                           r_ok,
    output lit_pkg::pos_t                  r_low,
    output lit_pkg::pos_t                  r_high,
    output logic                           r_last,
    output lit_pkg::pos_t                  r_lend,
    output logic                           r_lvalid
);
    import lit_pkg::*;

    pos_t mem [LANE_COUNT*MAX_BOUNDARIES];
    pos_t rd_data_reg;

    logic              func_reg;
    logic [LANE_W-1:0] lane_reg;
    pos_t              a_reg, b_reg;
    cnt_t              idx_reg, idx_next;   // scan / shift index
    cnt_t              lo_reg;              // index of first word >= start
    pos_t              q_lo_reg;
    logic              ok_reg;

    cnt_t cnt_reg  [LANE_COUNT];
    pos_t fend_reg [LANE_COUNT];
    pos_t road_start_reg, road_end_reg;

    logic              lane_ok;
    logic [LSEL_W-1:0] ln;
    cnt_t              n;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    pos_t              wr_data;
    logic              wr_en;
    logic              at_end;
    logic              scan_stop;
    pos_t              q_other;

    assign lane_ok = ({{(32-LANE_W){1'b0}}, lane_reg} < 32'(LANE_COUNT));
    assign ln      = LSEL_W'(lane_reg);
    assign n       = cnt_reg[ln];
    assign base    = ADDR_W'(ln) * ADDR_W'(MAX_BOUNDARIES);

    assign at_end  = (idx_reg >= n);

    // scan reads the next index, shift reads idx-1 (walking down),
    // query partner is word i-1 when i is odd and word i+1 when even
    always_comb begin
        rd_addr = base + ADDR_W'(idx_next);
        if (cmd.shift_rd) rd_addr = base + ADDR_W'(idx_reg - cnt_t'(1));
        if (cmd.q_rd_hi)  rd_addr = base + ADDR_W'(
            idx_reg[0] ? idx_reg - cnt_t'(1) : idx_reg + cnt_t'(1));
    end

    always_comb begin
        wr_en   = cmd.shift_wr || cmd.wr_start || cmd.wr_end;
        wr_addr = base + ADDR_W'(idx_reg + cnt_t'(1));
        wr_data = rd_data_reg;
        if (cmd.wr_start) begin
            wr_addr = base + ADDR_W'(lo_reg);
            wr_data = a_reg;
        end
        if (cmd.wr_end) begin
            wr_addr = base + ADDR_W'(lo_reg + cnt_t'(1));
            wr_data = b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (cmd.rd_issue || cmd.q_rd_hi) rd_data_reg <= mem[rd_addr];
    end

    // status
    assign scan_stop = at_end || (rd_data_reg >= a_reg);

    always_comb begin
        sts            = '0;
        sts.is_query   = func_reg;
        sts.lane_ok    = lane_ok;
        sts.pre_reject = func_reg ? (n < cnt_t'(2))
                       : ((a_reg >= b_reg) ||
                          ({1'b0, n} + (CNT_W+1)'(2) > (CNT_W+1)'(MAX_BOUNDARIES)));
        sts.scan_done  = scan_stop;
        sts.scan_end   = at_end;
        // insert: lo odd, or word at lo within [start, end]
        sts.ins_reject = idx_reg[0] || (!at_end && rd_data_reg <= b_reg);
        sts.shift_done = (idx_reg == lo_reg + cnt_t'(1));
        // query: past end, strictly below word at even index, or equal to it with no partner
        sts.q_miss     = at_end ||
                         (rd_data_reg != a_reg && !idx_reg[0]) ||
                         (rd_data_reg == a_reg && !idx_reg[0] &&
                          idx_reg + cnt_t'(1) >= n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg <= '0;
            idx_reg  <= '0;
        end else begin
            if (cmd.load) begin
                func_reg <= in_func;
                lane_reg <= in_lane;
                a_reg    <= in_a;
                b_reg    <= in_b;
            end
            idx_reg <= idx_next;
            if (cmd.scan_step && scan_stop) begin
                lo_reg <= idx_reg;
                if (!at_end) q_lo_reg <= rd_data_reg;
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.load) idx_next = '0;
        else if (cmd.scan_step && !scan_stop) idx_next = idx_reg + cnt_t'(1);
        else if (cmd.scan_step && !func_reg) idx_next = n;  // shift starts at the top
        else if (cmd.shift_wr) idx_next = idx_reg - cnt_t'(1);
    end

    // query: segment pair is (i-1,i) when i odd, (i,i+1) when i even and equal
    assign q_other = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANE_COUNT; i++) begin
                cnt_reg[i]  <= '0;
                fend_reg[i] <= '0;
            end
            road_start_reg <= '1;
            road_end_reg   <= '0;
            ok_reg         <= 1'b0;
        end else begin
            if (cmd.wr_end) begin
                cnt_reg[ln] <= n + cnt_t'(2);
                if (a_reg < road_start_reg) road_start_reg <= a_reg;
                if (b_reg > road_end_reg)   road_end_reg   <= b_reg;
                if (n == '0 || b_reg > fend_reg[ln]) fend_reg[ln] <= b_reg;
                ok_reg <= 1'b1;
            end
            if (cmd.load) ok_reg <= 1'b0;
            if (cmd.q_rd_hi) ok_reg <= 1'b1;
        end
    end

    // result build
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            r_ok     <= ok_reg;
            r_low    <= '0;
            r_high   <= '0;
            r_last   <= 1'b0;
            r_lvalid <= lane_ok && (n != '0);
            r_lend   <= (lane_ok && n != '0) ? fend_reg[ln] : '0;
            if (ok_reg && func_reg) begin
                if (lo_reg[0]) begin
                    r_low  <= q_other;
                    r_high <= q_lo_reg;
                    r_last <= (q_lo_reg == road_end_reg);
                end else begin
                    r_low  <= q_lo_reg;
                    r_high <= q_other;
                    r_last <= (q_other == road_end_reg);
                end
            end
        end
    end

    logic unused;
    assign unused = ^road_start_reg;

    `include "assert_macros.svh"

    `ASSERT_CLK(a_cnt_even, aclk, aresetn, !cnt_reg[ln][0], "odd boundary count")
    `ASSERT_CLK(a_cnt_max, aclk, aresetn, n <= cnt_t'(MAX_BOUNDARIES), "count over limit")

endmodule

`default_nettype wire

// ===== rtl/core/lane_interval_table_core.sv =====
// ----------------------------------------------------------------------------
// lane_interval_table_core
// per-lane sorted disjoint segment table with insert and point query
// ----------------------------------------------------------------------------
// One operation at a time. A beat rejected up front is loaded, checked and
// finished. Otherwise each boundary is compared in turn; an insert then moves
// each boundary above the new segment up and writes its start and end, and a
// query reads the partner word. The boundary memory is read one word at a time,
// with up to 16 boundaries per lane. The next beat is taken while a result waits
// on the output, but its result is not built until the previous one has left.
`default_nettype none

module lane_interval_table_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // func, lane[3], pos_a[32], pos_b[32], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [103:0] m_tdata  // ok, seg_low[32], seg_high[32], last_segment,
                                  // lane_end[32], lane_end_valid, zero pad
);
    import lit_pkg::*;

    lit_cmd_t cmd;
    lit_sts_t sts;
    logic r_ok, r_last, r_lvalid;
    pos_t r_low, r_high, r_lend;

    lit_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .cmd, .sts
    );

    lit_dp u_dp (
        .aclk, .aresetn,
        .in_func (s_tdata[0]),
        .in_lane (s_tdata[3:1]),
        .in_a    (s_tdata[35:4]),
        .in_b    (s_tdata[67:36]),
        .cmd, .sts,
        .r_ok, .r_low, .r_high, .r_last, .r_lend, .r_lvalid
    );

    assign m_tdata = {5'b0, r_lvalid, r_lend, r_last, r_high, r_low, r_ok};

    logic unused_pad;
    assign unused_pad = ^s_tdata[71:68];

endmodule

`default_nettype wire
